// ===== rtl/mbe_pkg.sv =====
package mbe_pkg;

  // fixed point format and image bounds
  localparam int MBE_FRAC_BITS  = 40;
  localparam int MBE_MAX_WIDTH  = 4096;
  localparam int MBE_MAX_HEIGHT = 4096;
  localparam int MBE_MAX_ITER   = 4096;

  // configuration register indexes
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_X_STEP   = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_LIMIT    = 3'd4;

  // configuration reset values
  localparam logic [63:0] RST_ORIGIN = 64'hFFFF_FE00_0000_0000;  // -2.0
  localparam logic [63:0] RST_STEP   = 64'h0000_0001_0000_0000;  // 2^-8
  localparam logic [12:0] RST_LIMIT  = 13'd256;

  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SQ,
    ST_DONE
  } mbe_state_t;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MOP_CR,
    MOP_CI,
    MOP_ZRR,
    MOP_ZII,
    MOP_ZRI
  } mbe_mop_t;

  // where a finished product goes
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_CR,
    CAP_CI,
    CAP_RR,
    CAP_II,
    CAP_RI
  } mbe_cap_t;

  typedef struct packed {
    logic     load_px;
    mbe_mop_t mop;
    mbe_cap_t cap;
    logic     upd_z;
    logic     cnt_inc;
    logic     out_load;
  } mbe_cmd_t;

  typedef struct packed {
    logic lim_small;
    logic below;
    logic cnt_last;
  } mbe_sts_t;

  function automatic logic [63:0] sat_of(input logic [63:0] a);
    return a[63] ? SAT_MIN : SAT_MAX;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // signed 128 bit to signed 64 bit, saturating
  function automatic logic [63:0] sat64(input logic [127:0] x);
    logic fits;
    fits = (x[127:63] == '0) || (x[127:63] == '1);
    return fits ? x[63:0] : (x[127] ? SAT_MIN : SAT_MAX);
  endfunction

  // drop fraction bits (floor), then saturate
  function automatic logic [63:0] fix_sat(input logic [127:0] x);
    logic signed [127:0] s;
    s = $signed(x) >>> MBE_FRAC_BITS;
    return sat64(s);
  endfunction

  function automatic logic [63:0] add_s(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] ovf;
    r   = a + b;
    ovf = (a ^ r) & (b ^ r);
    return ovf[63] ? sat_of(a) : r;
  endfunction

  function automatic logic [63:0] sub_s(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] ovf;
    r   = a - b;
    ovf = (a ^ b) & (a ^ r);
    return ovf[63] ? sat_of(a) : r;
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_counter_unit.sv =====
// When the limit is below three, a pixel finishes after the setup of c with
//   no iteration run.
// The unit works on one pixel at a time; each iteration is paced by the one
//   shared 64x64 multiplier (three products per iteration, three-stage pipe).
// Reset (rst_n, synchronous): control idles, configuration registers take their defaults.
module mandelbrot_escape_counter_unit import mbe_pkg::*; #(
  parameter int MAX_ITER = MBE_MAX_ITER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_iteration_count
);

  mbe_cmd_t cmd;
  mbe_sts_t sts;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbe_datapath #(
    .MAX_ITER (MAX_ITER)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_column           (in_column),
    .in_row              (in_row),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_iteration_count (out_iteration_count)
  );

endmodule

// ===== rtl/mbe_mul64.sv =====
module mbe_mul64 import mbe_pkg::*; (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  input  logic         neg,
  output logic [127:0] mag_o,
  output logic [127:0] prod_o
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic         neg1_r, neg2_r;
  logic [127:0] sum_r;
  logic [127:0] mag3_r, prod3_r;
  logic [127:0] sum_nxt;

  // stage 2: combine partial products
  assign sum_nxt = {64'd0, ll_r}
                 + {32'd0, lh_r, 32'd0}
                 + {32'd0, hl_r, 32'd0}
                 + {hh_r, 64'd0};

  always_ff @(posedge clk) begin
    // stage 1: four 32x32 partial products
    ll_r    <= 64'(a[31:0])  * 64'(b[31:0]);
    lh_r    <= 64'(a[31:0])  * 64'(b[63:32]);
    hl_r    <= 64'(a[63:32]) * 64'(b[31:0]);
    hh_r    <= 64'(a[63:32]) * 64'(b[63:32]);
    neg1_r  <= neg;
    sum_r   <= sum_nxt;
    neg2_r  <= neg1_r;
    // stage 3: apply sign
    mag3_r  <= sum_r;
    prod3_r <= neg2_r ? (128'd0 - sum_r) : sum_r;
  end

  assign mag_o  = mag3_r;
  assign prod_o = prod3_r;

endmodule

// ===== rtl/mbe_datapath.sv =====
module mbe_datapath import mbe_pkg::*; #(
  parameter int MAX_ITER = MBE_MAX_ITER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  input  mbe_cmd_t    cmd,
  output mbe_sts_t    sts,
  output logic [11:0] out_iteration_count
);

  localparam int LIM_W = $clog2(MAX_ITER + 1);
  localparam int THR_W = 2 * LIM_W;

  logic [63:0] x_origin_r, y_origin_r, x_step_r, y_step_r;
  logic [12:0] limit_r;

  logic [11:0]      col_r, row_r;
  logic [LIM_W-1:0] lim_r, count_r;
  logic [THR_W-1:0] thr_r;
  logic [63:0]      cr_r, ci_r, zr_r, zi_r, rr_r, ii_r, ri_r;
  logic [127:0]     sqr_r, sqi_r;
  logic [11:0]      out_count_r;

  logic [11:0]      col_nxt, row_nxt;
  logic [LIM_W-1:0] lim_nxt;
  logic [63:0]      op_a, op_b;
  logic             op_neg;
  logic [127:0]     mag, prod;
  logic [127:0]     sq_sum, sq_int;
  logic [31:0]      cnt32;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= RST_ORIGIN;
      y_origin_r <= RST_ORIGIN;
      x_step_r   <= RST_STEP;
      y_step_r   <= RST_STEP;
      limit_r    <= RST_LIMIT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_X_ORIGIN: x_origin_r <= cfg_data;
        REG_Y_ORIGIN: y_origin_r <= cfg_data;
        REG_X_STEP:   x_step_r   <= cfg_data;
        REG_Y_STEP:   y_step_r   <= cfg_data;
        REG_LIMIT:    limit_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamp pixel coordinates and limit on entry
  always_comb begin
    col_nxt = (32'(in_column) > MBE_MAX_WIDTH - 1)  ? 12'(MBE_MAX_WIDTH - 1)  : in_column;
    row_nxt = (32'(in_row)    > MBE_MAX_HEIGHT - 1) ? 12'(MBE_MAX_HEIGHT - 1) : in_row;
    lim_nxt = (32'(limit_r) > MAX_ITER) ? LIM_W'(MAX_ITER) : LIM_W'(limit_r);
  end

  // multiplier operand select
  always_comb begin
    op_a   = mag64(zr_r);
    op_b   = mag64(zr_r);
    op_neg = 1'b0;
    case (cmd.mop)
      MOP_CR: begin
        op_a   = 64'(col_r);
        op_b   = mag64(x_step_r);
        op_neg = x_step_r[63];
      end
      MOP_CI: begin
        op_a   = 64'(row_r);
        op_b   = mag64(y_step_r);
        op_neg = y_step_r[63];
      end
      MOP_ZRR: begin
        op_a = mag64(zr_r);
        op_b = mag64(zr_r);
      end
      MOP_ZII: begin
        op_a = mag64(zi_r);
        op_b = mag64(zi_r);
      end
      MOP_ZRI: begin
        op_a   = mag64(zr_r);
        op_b   = mag64(zi_r);
        op_neg = zr_r[63] ^ zi_r[63];
      end
      default: ;
    endcase
  end

  mbe_mul64 u_mul (
    .clk    (clk),
    .a      (op_a),
    .b      (op_b),
    .neg    (op_neg),
    .mag_o  (mag),
    .prod_o (prod)
  );

  // pixel working registers
  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      lim_r   <= lim_nxt;
      thr_r   <= THR_W'(lim_nxt) * THR_W'(lim_nxt);
      count_r <= LIM_W'(1);
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + LIM_W'(1);
    end

    case (cmd.cap)
      CAP_CR: begin
        cr_r <= add_s(sat64(prod), x_origin_r);
        zr_r <= add_s(sat64(prod), x_origin_r);
      end
      CAP_CI: begin
        ci_r <= add_s(sat64(prod), y_origin_r);
        zi_r <= add_s(sat64(prod), y_origin_r);
      end
      CAP_RR: begin
        rr_r  <= fix_sat(prod);
        sqr_r <= mag;
      end
      CAP_II: begin
        ii_r  <= fix_sat(prod);
        sqi_r <= mag;
      end
      CAP_RI: ri_r <= fix_sat(prod);
      default: ;
    endcase

    // z <- z^2 + c
    if (cmd.upd_z) begin
      zr_r <= add_s(sub_s(rr_r, ii_r), cr_r);
      zi_r <= add_s(add_s(ri_r, ri_r), ci_r);
    end

    if (cmd.out_load) begin
      out_count_r <= (cnt32 > 32'd4095) ? 12'hFFF : cnt32[11:0];
    end
  end

  // escape test on exact sum of squares
  always_comb begin
    sq_sum        = sqr_r + sqi_r;
    sq_int        = sq_sum >> (2 * MBE_FRAC_BITS);
    cnt32         = 32'(count_r);
    sts.below     = sq_int < 128'(thr_r);
    sts.lim_small = lim_r < LIM_W'(3);
    sts.cnt_last  = (cnt32 + 32'd2) >= 32'(lim_r);
  end

  assign out_iteration_count = out_count_r;

endmodule

// ===== rtl/mbe_ctrl.sv =====
module mbe_ctrl import mbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mbe_sts_t sts,
  output mbe_cmd_t cmd
);

  mbe_state_t state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 3'd0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencer: set up c, then one pass of three products per iteration
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mop       = MOP_ZRR;
    cmd.cap       = CAP_NONE;

    case (state_r)
      ST_IDLE: begin
        // no word is taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load_px = 1'b1;
          ph_nxt      = 3'd0;
          state_nxt   = ST_INIT;
        end
      end

      ST_INIT: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: cmd.mop = MOP_CR;
          3'd1: cmd.mop = MOP_CI;
          3'd3: cmd.cap = CAP_CR;
          3'd4: begin
            cmd.cap   = CAP_CI;
            ph_nxt    = 3'd0;
            first_nxt = 1'b1;
            state_nxt = sts.lim_small ? ST_DONE : ST_SQ;
          end
          default: ;
        endcase
      end

      ST_SQ: begin
        ph_nxt = ph_r + 3'd1;
        case (ph_r)
          3'd0: cmd.mop = MOP_ZRR;
          3'd1: cmd.mop = MOP_ZII;
          3'd2: cmd.mop = MOP_ZRI;
          3'd3: cmd.cap = CAP_RR;
          3'd4: cmd.cap = CAP_II;
          3'd5: begin
            cmd.cap = CAP_RI;
            // squares of the latest z are ready: escape check
            if (!first_r) begin
              if (!sts.below) begin
                state_nxt = ST_DONE;
              end else begin
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last) state_nxt = ST_DONE;
              end
            end
          end
          3'd6: begin
            cmd.upd_z = 1'b1;
            first_nxt = 1'b0;
            ph_nxt    = 3'd0;
          end
          default: ph_nxt = 3'd0;
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  // checks
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result word loaded over a pending one");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_INIT && ph_r == 3'd0))
    else $error("accepted word did not start setup");

  a_inc_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (sts.below && !first_r && state_r == ST_SQ))
    else $error("count raised without a passing escape test");

  a_init_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> (ph_r <= 3'd4))
    else $error("setup phase out of range");

endmodule
